>>> hdl/rot_pkg.sv
// Shared types and constants for the recency-ordered entry table.
// Holds the entry record, the operation codes and the result bundle.
// No dependencies.
`default_nettype none

package rot_pkg;

  localparam int SlotsDefault = 16;

  typedef enum logic [2:0] {
    MODE_ADD     = 3'd0,
    MODE_DEL_ID  = 3'd1,
    MODE_DEL_SEL = 3'd2,
    MODE_SELECT  = 3'd3,
    MODE_READ    = 3'd4,
    MODE_FIND    = 3'd5,
    MODE_CLEAR   = 3'd6
  } mode_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] key;
    logic        kind;
    logic [15:0] rep;
    logic [31:0] stamp;
  } entry_t;

  // Result of one request, valid for one cycle at the end of its work.
  typedef struct packed {
    logic        valid;
    logic        status;
    logic        found;
    logic [3:0]  fpos;
    logic        kind;
    logic [31:0] id;
    logic [15:0] rep;
    logic [31:0] stamp;
  } fin_t;

endpackage

`default_nettype wire

>>> hdl/recency_ordered_entry_table.sv
// Top level of the recency-ordered entry table: sequencer, entry memory and
// result register. Uses rot_pkg, rot_entry_mem and rot_ctrl.
`default_nettype none

// A request is taken at a rising edge with start high and busy low; its result
// shows on the result ports for exactly one cycle with done high, and the
// receiver cannot stall it. Entries live in one synchronous memory in list
// order, oldest at position 0, so every scan, delete and merge walks that
// memory through its single read port, one entry per cycle, and the shift
// that closes a gap writes each entry back one position lower. Select, clear
// and requests refused without a scan finish from idle; read passes through a
// read wait; an add that needs no scan or eviction goes straight to writing
// the newest entry; find and delete by id scan from position 0 to the match or
// to the newest entry; a delete or eviction adds the shift; a missed-call add
// scans up to its match, or the whole table, then shifts if it merges or
// evicts, and writes the newest entry. The counts and selected_position show
// the state after the request while done is high.
// No clearing pass follows reset: the table is empty at once.
module recency_ordered_entry_table
  import rot_pkg::*;
#(
  parameter int SLOTS = SlotsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  mode,
  input  wire logic [31:0] entry_id,
  input  wire logic [31:0] caller_key,
  input  wire logic        kind,
  input  wire logic [31:0] stamp,
  input  wire logic [3:0]  position,
  output logic             done,
  output logic             status,
  output logic             found,
  output logic [3:0]       found_position,
  output logic [31:0]      read_id,
  output logic [15:0]      repeat_count,
  output logic             read_kind,
  output logic [31:0]      read_stamp,
  output logic [4:0]       used_count,
  output logic [4:0]       missed_count,
  output logic [4:0]       message_count,
  output logic [3:0]       selected_position
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  entry_t        rd, wdata;
  logic [IW-1:0] raddr, waddr, sel;
  logic          we;
  fin_t          fin;
  logic [CW-1:0] held, missed, message;

  rot_entry_mem #(.SLOTS(SLOTS)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd)
  );

  rot_ctrl #(.SLOTS(SLOTS)) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .mode       (mode),
    .entry_id   (entry_id),
    .caller_key (caller_key),
    .kind       (kind),
    .stamp      (stamp),
    .position   (position),
    .busy       (busy),
    .rd         (rd),
    .mem_raddr  (raddr),
    .mem_we     (we),
    .mem_waddr  (waddr),
    .mem_wdata  (wdata),
    .fin        (fin),
    .held       (held),
    .missed     (missed),
    .message    (message),
    .sel        (sel)
  );

  // Hold the result of the finished request for its one cycle on the ports.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
    if (fin.valid) begin
      status         <= fin.status;
      found          <= fin.found;
      found_position <= fin.fpos;
      read_id        <= fin.id;
      repeat_count   <= fin.rep;
      read_kind      <= fin.kind;
      read_stamp     <= fin.stamp;
    end
  end

  // Report live state; it has settled by the time done is shown.
  assign used_count        = 5'(held);
  assign missed_count      = 5'(missed);
  assign message_count     = 5'(message);
  assign selected_position = 4'(sel);

endmodule

`default_nettype wire

>>> hdl/rot_entry_mem.sv
// Entry memory, indexed by list position (oldest first).
// One write port, one read port, read data registered. Uses rot_pkg.
`default_nettype none

module rot_entry_mem
  import rot_pkg::*;
#(
  parameter int SLOTS = SlotsDefault,
  localparam int IW = $clog2(SLOTS)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [IW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [IW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hdl/rot_ctrl.sv
// Request sequencer: scans, shifts and appends entries in the entry memory
// and keeps the counts and the selection. Uses rot_pkg.
`default_nettype none

module rot_ctrl
  import rot_pkg::*;
#(
  parameter int SLOTS = SlotsDefault,
  localparam int IW = $clog2(SLOTS),
  localparam int CW = $clog2(SLOTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [2:0]    mode,
  input  wire logic [31:0]   entry_id,
  input  wire logic [31:0]   caller_key,
  input  wire logic          kind,
  input  wire logic [31:0]   stamp,
  input  wire logic [3:0]    position,
  output logic               busy,
  input  wire entry_t        rd,
  output logic [IW-1:0]      mem_raddr,
  output logic               mem_we,
  output logic [IW-1:0]      mem_waddr,
  output entry_t             mem_wdata,
  output fin_t               fin,
  output logic [CW-1:0]      held,
  output logic [CW-1:0]      missed,
  output logic [CW-1:0]      message,
  output logic [IW-1:0]      sel
);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_SHIFT, S_TAIL, S_RDWAIT
  } state_t;

  state_t        state, state_next;
  mode_t         req_mode, req_mode_next;
  logic [31:0]   req_id, req_id_next;
  logic [31:0]   req_key, req_key_next;
  logic          req_kind, req_kind_next;
  logic [31:0]   req_stamp, req_stamp_next;
  logic [CW-1:0] held_next, missed_next, message_next;
  logic [IW-1:0] sel_next;
  logic [IW-1:0] ra, ra_next;
  logic          stop, stop_next;
  logic          rv, rv_next;
  logic [IW-1:0] rq, rq_next;
  logic [IW-1:0] p, p_next;
  logic          append, append_next;
  logic          merge, merge_next;
  logic          by_key, by_key_next;
  entry_t        victim, victim_next;

  logic [IW-1:0] last_idx;
  logic          hit, at_end, issue, vkind;
  entry_t        tail_entry;

  assign busy     = (state != S_IDLE);
  assign last_idx = IW'(held - 1'b1);
  assign hit      = rv && (by_key ? (rd.kind && rd.key == req_key) : (rd.id == req_id));
  assign at_end   = rv && (rq == last_idx);
  assign issue    = ((state == S_SCAN) && !stop && !hit) || ((state == S_SHIFT) && !stop);

  always_comb begin
    if (merge) begin
      tail_entry = '{id: victim.id, key: victim.key, kind: victim.kind,
                     rep: victim.rep + 16'd1, stamp: req_stamp};
    end else begin
      tail_entry = '{id: req_id, key: req_key, kind: req_kind,
                     rep: {15'd0, req_kind}, stamp: req_stamp};
    end
  end

  assign mem_raddr = (state == S_IDLE) ? IW'(position) : ra;
  assign mem_we    = ((state == S_SHIFT) && rv && (rq != p)) || (state == S_TAIL);
  assign mem_waddr = (state == S_TAIL) ? IW'(held) : IW'(rq - 1'b1);
  assign mem_wdata = (state == S_TAIL) ? tail_entry : rd;
  assign vkind     = (rq == p) ? rd.kind : victim.kind;

  always_comb begin
    state_next     = state;
    req_mode_next  = req_mode;
    req_id_next    = req_id;
    req_key_next   = req_key;
    req_kind_next  = req_kind;
    req_stamp_next = req_stamp;
    held_next      = held;
    missed_next    = missed;
    message_next   = message;
    sel_next       = sel;
    ra_next        = ra;
    stop_next      = stop;
    rv_next        = issue;
    rq_next        = ra;
    p_next         = p;
    append_next    = append;
    merge_next     = merge;
    by_key_next    = by_key;
    victim_next    = victim;
    fin            = '0;

    // Walk the read address up to the newest entry.
    if (issue) begin
      stop_next = (ra == last_idx);
      ra_next   = (ra == last_idx) ? ra : IW'(ra + 1'b1);
    end

    case (state)
      S_IDLE: begin
        if (start) begin
          req_mode_next  = mode_t'(mode);
          req_id_next    = entry_id;
          req_key_next   = caller_key;
          req_kind_next  = kind;
          req_stamp_next = stamp;
          case (mode_t'(mode))
            MODE_ADD: begin
              if (kind && held != '0) begin
                state_next  = S_SCAN;
                by_key_next = 1'b1;
                ra_next     = '0;
                stop_next   = 1'b0;
              end else if (held == CW'(SLOTS)) begin
                state_next  = S_SHIFT;
                p_next      = '0;
                ra_next     = '0;
                stop_next   = 1'b0;
                append_next = 1'b1;
                merge_next  = 1'b0;
              end else begin
                state_next = S_TAIL;
                merge_next = 1'b0;
              end
            end
            MODE_DEL_ID, MODE_FIND: begin
              if (held != '0) begin
                state_next  = S_SCAN;
                by_key_next = 1'b0;
                ra_next     = '0;
                stop_next   = 1'b0;
              end else begin
                fin.valid  = 1'b1;
                fin.status = 1'b1;
              end
            end
            MODE_DEL_SEL: begin
              if (CW'(sel) < held) begin
                state_next  = S_SHIFT;
                p_next      = sel;
                ra_next     = sel;
                stop_next   = 1'b0;
                append_next = 1'b0;
                if (sel != '0) begin
                  sel_next = IW'(sel - 1'b1);
                end
              end else begin
                fin.valid  = 1'b1;
                fin.status = 1'b1;
              end
            end
            MODE_SELECT: begin
              fin.valid = 1'b1;
              if (32'(position) < 32'(held)) begin
                sel_next = IW'(position);
              end else begin
                fin.status = 1'b1;
              end
            end
            MODE_READ: begin
              if (32'(position) < 32'(held)) begin
                state_next = S_RDWAIT;
              end else begin
                fin.valid  = 1'b1;
                fin.status = 1'b1;
              end
            end
            MODE_CLEAR: begin
              held_next    = '0;
              missed_next  = '0;
              message_next = '0;
              sel_next     = '0;
              fin.valid    = 1'b1;
            end
            default: begin
              fin.valid  = 1'b1;
              fin.status = 1'b1;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit) begin
          case (req_mode)
            MODE_ADD: begin
              state_next  = S_SHIFT;
              p_next      = rq;
              ra_next     = rq;
              stop_next   = 1'b0;
              append_next = 1'b1;
              merge_next  = 1'b1;
              if (sel == rq) begin
                sel_next = last_idx;
              end
            end
            MODE_DEL_ID: begin
              state_next  = S_SHIFT;
              p_next      = rq;
              ra_next     = rq;
              stop_next   = 1'b0;
              append_next = 1'b0;
              if (rq == sel && sel != '0) begin
                sel_next = IW'(sel - 1'b1);
              end
            end
            default: begin
              state_next = S_IDLE;
              fin.valid  = 1'b1;
              fin.found  = 1'b1;
              fin.fpos   = 4'(rq);
              fin.kind   = rd.kind;
            end
          endcase
        end else if (at_end) begin
          if (req_mode == MODE_ADD) begin
            merge_next = 1'b0;
            if (held == CW'(SLOTS)) begin
              state_next  = S_SHIFT;
              p_next      = '0;
              ra_next     = '0;
              stop_next   = 1'b0;
              append_next = 1'b1;
            end else begin
              state_next = S_TAIL;
            end
          end else begin
            state_next = S_IDLE;
            fin.valid  = 1'b1;
            fin.status = 1'b1;
          end
        end
      end

      S_SHIFT: begin
        // Capture the removed entry, move every newer one down by one.
        if (rv && rq == p) begin
          victim_next = rd;
        end
        if (at_end) begin
          held_next = CW'(held - 1'b1);
          if (vkind) begin
            if (missed != '0) missed_next = CW'(missed - 1'b1);
          end else begin
            if (message != '0) message_next = CW'(message - 1'b1);
          end
          if (append) begin
            state_next = S_TAIL;
          end else begin
            state_next = S_IDLE;
            fin.valid  = 1'b1;
          end
        end
      end

      S_TAIL: begin
        held_next = CW'(held + 1'b1);
        if (req_kind) begin
          missed_next = CW'(missed + 1'b1);
        end else begin
          message_next = CW'(message + 1'b1);
        end
        state_next = S_IDLE;
        fin.valid  = 1'b1;
      end

      S_RDWAIT: begin
        state_next = S_IDLE;
        fin.valid  = 1'b1;
        fin.id     = rd.id;
        fin.rep    = rd.rep;
        fin.kind   = rd.kind;
        fin.stamp  = rd.stamp;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      held    <= '0;
      missed  <= '0;
      message <= '0;
      sel     <= '0;
      rv      <= 1'b0;
      stop    <= 1'b1;
    end else begin
      state   <= state_next;
      held    <= held_next;
      missed  <= missed_next;
      message <= message_next;
      sel     <= sel_next;
      rv      <= rv_next;
      stop    <= stop_next;
    end
    req_mode  <= req_mode_next;
    req_id    <= req_id_next;
    req_key   <= req_key_next;
    req_kind  <= req_kind_next;
    req_stamp <= req_stamp_next;
    ra        <= ra_next;
    rq        <= rq_next;
    p         <= p_next;
    append    <= append_next;
    merge     <= merge_next;
    by_key    <= by_key_next;
    victim    <= victim_next;
  end

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held <= CW'(SLOTS))
    else $error("held count exceeds slot count");

  a_count_sum: assert property (@(posedge clk) disable iff (rst)
    ((CW+1)'(missed) + (CW+1)'(message)) == (CW+1)'(held))
    else $error("category counts do not add up to held count");

  a_read_wait: assert property (@(posedge clk) disable iff (rst)
    (state == S_RDWAIT) |-> ($past(state) == S_IDLE))
    else $error("read wait not entered from idle");

  a_fin_idle: assert property (@(posedge clk) disable iff (rst)
    fin.valid |=> (state == S_IDLE))
    else $error("sequencer not idle after result");

endmodule

`default_nettype wire

>>> tb/sv/recency_ordered_entry_table_tb.sv
// Self-checking testbench for the recency-ordered entry table.
// Drives requests from a queue, predicts every result with a behavioral table
// model, and checks each done strobe field by field. Depends on rot_pkg and the RTL.
`default_nettype none

module recency_ordered_entry_table_tb;
  import rot_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;

  // One pending request as the driver sees it.
  typedef struct {
    logic [2:0]  mode;
    logic [31:0] id;
    logic [31:0] key;
    logic        kind;
    logic [31:0] stamp;
    logic [3:0]  pos;
  } request_t;

  // One predicted result.
  typedef struct {
    logic        status;
    logic        found;
    logic [3:0]  fpos;
    logic [31:0] id;
    logic [15:0] rep;
    logic        kind;
    logic [31:0] stamp;
    logic [4:0]  used;
    logic [4:0]  missed;
    logic [4:0]  msgs;
    logic [3:0]  sel;
  } table_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic [2:0]  mode = '0;
  logic [31:0] entry_id = '0;
  logic [31:0] caller_key = '0;
  logic        kind = 1'b0;
  logic [31:0] stamp = '0;
  logic [3:0]  position = '0;
  logic        busy, done, status, found, read_kind;
  logic [3:0]  found_position, selected_position;
  logic [31:0] read_id, read_stamp;
  logic [15:0] repeat_count;
  logic [4:0]  used_count, missed_count, message_count;

  recency_ordered_entry_table u_dut (
    .clk, .rst, .start, .busy, .mode, .entry_id, .caller_key, .kind, .stamp,
    .position, .done, .status, .found, .found_position, .read_id, .repeat_count,
    .read_kind, .read_stamp, .used_count, .missed_count, .message_count,
    .selected_position
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predictor state: entries kept directly in list order, oldest first.
  entry_t        tbl_entries[$];
  logic [3:0]    tbl_sel;
  int            tbl_missed, tbl_msgs;

  request_t      pending_requests[$];
  table_result_t expected_results[$];
  int            errors = 0;
  int            checked = 0;
  int            merges = 0;
  int            evictions = 0;

  // Drop the entry at list position p and keep the category counts.
  function automatic void drop_at(int p);
    if (tbl_entries[p].kind) begin
      if (tbl_missed > 0) tbl_missed--;
    end else begin
      if (tbl_msgs > 0) tbl_msgs--;
    end
    tbl_entries.delete(p);
  endfunction

  function automatic int position_of(logic [31:0] id);
    foreach (tbl_entries[i]) if (tbl_entries[i].id == id) return i;
    return -1;
  endfunction

  // Apply one request to the predictor and return the expected result.
  function automatic table_result_t predict_table(request_t r);
    table_result_t res;
    entry_t        e;
    int            p;
    bit            merged;
    res = '{default: '0};
    case (r.mode)
      MODE_ADD: begin
        merged = 1'b0;
        p = -1;
        if (r.kind) begin
          foreach (tbl_entries[i]) begin
            if (p < 0 && tbl_entries[i].kind && tbl_entries[i].key == r.key) p = i;
          end
        end
        if (p >= 0) begin
          e = tbl_entries[p];
          e.rep = e.rep + 16'd1;
          e.stamp = r.stamp;
          tbl_entries.delete(p);
          tbl_entries.push_back(e);
          if (tbl_sel == p) tbl_sel = 4'(tbl_entries.size() - 1);
          merged = 1'b1;
          merges++;
        end
        if (!merged) begin
          if (tbl_entries.size() == NSLOT) begin
            drop_at(0);
            evictions++;
          end
          e.id = r.id;
          e.key = r.key;
          e.kind = r.kind;
          e.stamp = r.stamp;
          e.rep = r.kind ? 16'd1 : 16'd0;
          if (r.kind) tbl_missed++;
          else tbl_msgs++;
          tbl_entries.push_back(e);
        end
      end
      MODE_DEL_ID: begin
        p = position_of(r.id);
        if (p >= 0) begin
          drop_at(p);
          if (p == tbl_sel && tbl_sel > 0) tbl_sel--;
        end else begin
          res.status = 1'b1;
        end
      end
      MODE_DEL_SEL: begin
        if (tbl_sel < tbl_entries.size()) begin
          drop_at(tbl_sel);
          if (tbl_sel > 0) tbl_sel--;
        end else begin
          res.status = 1'b1;
        end
      end
      MODE_SELECT: begin
        if (r.pos < tbl_entries.size()) tbl_sel = r.pos;
        else res.status = 1'b1;
      end
      MODE_READ: begin
        if (r.pos < tbl_entries.size()) begin
          e = tbl_entries[r.pos];
          res.id = e.id;
          res.rep = e.rep;
          res.kind = e.kind;
          res.stamp = e.stamp;
        end else begin
          res.status = 1'b1;
        end
      end
      MODE_FIND: begin
        p = position_of(r.id);
        if (p >= 0) begin
          res.found = 1'b1;
          res.fpos = 4'(p);
          res.kind = tbl_entries[p].kind;
        end else begin
          res.status = 1'b1;
        end
      end
      MODE_CLEAR: begin
        tbl_entries.delete();
        tbl_missed = 0;
        tbl_msgs = 0;
        tbl_sel = '0;
      end
      default: res.status = 1'b1;
    endcase
    res.used = 5'(tbl_entries.size());
    res.missed = 5'(tbl_missed);
    res.msgs = 5'(tbl_msgs);
    res.sel = tbl_sel;
    return res;
  endfunction

  // Sample busy at each rising edge so the driver knows whether start was taken.
  logic busy_at_edge = 1'b1;
  always @(posedge clk) busy_at_edge <= busy;

  // Driver: wait a random gap, raise start, hold until the request is taken.
  int  gap_left = 0;
  bit  gap_drawn = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (start && !busy_at_edge) begin
        // The request was taken at the last rising edge; advance the queue.
        expected_results.push_back(predict_table(pending_requests.pop_front()));
      end
      if (start && busy_at_edge) begin
        // Hold the request until the block takes it.
      end else if (pending_requests.size() == 0) begin
        start <= 1'b0;
      end else begin
        if (!gap_drawn) begin
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
          gap_drawn = 1'b1;
        end
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else begin
          gap_drawn = 1'b0;
          start <= 1'b1;
          mode <= pending_requests[0].mode;
          entry_id <= pending_requests[0].id;
          caller_key <= pending_requests[0].key;
          kind <= pending_requests[0].kind;
          stamp <= pending_requests[0].stamp;
          position <= pending_requests[0].pos;
        end
      end
    end
  end

  // Monitor: compare each strobe with the oldest expectation.
  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    table_result_t x;
    if (!rst && done) begin
      // A strobe at the same edge as acceptance cannot exist: done is registered after the request is taken.
      if (expected_results.size() == 0) begin
        $error("result strobe with no request outstanding");
        errors++;
      end else begin
        x = expected_results.pop_front();
        checked++;
        compare_field("status", x.status, status);
        compare_field("found", x.found, found);
        compare_field("found_position", x.fpos, found_position);
        compare_field("read_id", x.id, read_id);
        compare_field("repeat_count", x.rep, repeat_count);
        compare_field("read_kind", x.kind, read_kind);
        compare_field("read_stamp", x.stamp, read_stamp);
        compare_field("used_count", x.used, used_count);
        compare_field("missed_count", x.missed, missed_count);
        compare_field("message_count", x.msgs, message_count);
        compare_field("selected_position", x.sel, selected_position);
      end
    end
  end

  function automatic request_t make_request(logic [2:0] m, logic [31:0] id, logic [31:0] key,
                                            logic k, logic [31:0] st, logic [3:0] p);
    request_t r;
    r.mode = m;
    r.id = id;
    r.key = key;
    r.kind = k;
    r.stamp = st;
    r.pos = p;
    return r;
  endfunction

  // Draw a random request; ids and keys come from small pools so that
  // finds, deletes and merges hit, with full-width values mixed in.
  function automatic request_t random_request();
    int       pick;
    logic [2:0] m;
    logic [31:0] id, key;
    pick = $urandom_range(0, 99);
    if (pick < 45) m = MODE_ADD;
    else if (pick < 55) m = MODE_DEL_ID;
    else if (pick < 62) m = MODE_DEL_SEL;
    else if (pick < 72) m = MODE_SELECT;
    else if (pick < 86) m = MODE_READ;
    else if (pick < 96) m = MODE_FIND;
    else if (pick < 98) m = MODE_CLEAR;
    else m = 3'd7;
    id = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 40));
    key = ($urandom_range(0, 3) == 0) ? $urandom() : 32'($urandom_range(0, 5));
    return make_request(m, id, key, 1'($urandom_range(0, 1)), $urandom(),
                        4'($urandom_range(0, 15)));
  endfunction

  initial begin
    tbl_sel = '0;
    tbl_missed = 0;
    tbl_msgs = 0;
    // Directed part: empty-table failures, invalid mode, extremes, merge.
    pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 4'd0));
    pending_requests.push_back(make_request(MODE_DEL_SEL, 0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_SELECT, 0, 0, 0, 0, 4'd15));
    pending_requests.push_back(make_request(MODE_FIND, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_DEL_ID, 32'd5, 0, 0, 0, 0));
    pending_requests.push_back(make_request(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                            32'hFFFF_FFFF, 4'hF));
    pending_requests.push_back(make_request(MODE_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1,
                                            32'hFFFF_FFFF, 0));
    pending_requests.push_back(make_request(MODE_ADD, 32'd0, 32'd0, 0, 32'd0, 0));
    pending_requests.push_back(make_request(MODE_ADD, 32'd7, 32'hFFFF_FFFF, 1, 32'd9, 0));
    pending_requests.push_back(make_request(MODE_SELECT, 0, 0, 0, 0, 4'd0));
    // Merge the missed call once more while position 0 is selected; the selection stays.
    pending_requests.push_back(make_request(MODE_ADD, 32'd8, 32'hFFFF_FFFF, 1, 32'd10, 0));
    pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 4'd2));
    pending_requests.push_back(make_request(MODE_FIND, 32'd0, 0, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_DEL_ID, 32'hFFFF_FFFF, 0, 0, 0, 0));
    pending_requests.push_back(make_request(MODE_DEL_SEL, 0, 0, 0, 0, 0));
    // Fill past capacity to force an eviction, then read the newest slot.
    for (int i = 0; i < 17; i++)
      pending_requests.push_back(make_request(MODE_ADD, 32'(100 + i), 32'(i), 0, 32'(i), 0));
    pending_requests.push_back(make_request(MODE_READ, 0, 0, 0, 0, 4'd15));
    pending_requests.push_back(make_request(MODE_CLEAR, 0, 0, 0, 0, 0));
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < 1200; i++) pending_requests.push_back(random_request());
    wait (pending_requests.size() == 0 && expected_results.size() == 0);
    repeat (60) @(posedge clk);
    $display("Checked %0d results: %0d merges, %0d evictions, all modes and failures.",
             checked, merges, evictions);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timeout with %0d results outstanding.", expected_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule

`default_nettype wire
